### hw/rtl/fdm_pkg.sv
// Shared constants and types for the FAT directory entry name match block.
package fdm_pkg;

   localparam int unsigned NAME_LOW_W  = 64;
   localparam int unsigned NAME_HIGH_W = 24;
   localparam int unsigned ATTR_W      = 8;
   localparam int unsigned HALF_W      = 16;
   localparam int unsigned CLUSTER_W   = 2 * HALF_W;
   localparam int unsigned REQ_DATA_W  = NAME_LOW_W + NAME_HIGH_W + ATTR_W + 2 * HALF_W;
   localparam int unsigned RSP_DATA_W  = CLUSTER_W;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [7:0] DELETED_MARK = 8'hE5;
   localparam logic [7:0] KANJI_MARK   = 8'h05;
   localparam logic [7:0] END_MARK     = 8'h00;
   localparam int unsigned DIR_ATTR_BIT = 4;

   localparam logic [NAME_LOW_W-1:0]  TARGET_LOW_RESET  = 64'h2020202020202020;
   localparam logic [NAME_HIGH_W-1:0] TARGET_HIGH_RESET = 24'h202020;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WANT_DIR    = 2'd2;

   typedef enum logic [2:0] {
      ST_NONE      = 3'd0,
      ST_FOUND     = 3'd1,
      ST_END       = 3'd2,
      ST_EXHAUSTED = 3'd3,
      ST_IGNORED   = 3'd4
   } status_type;

   typedef struct packed {
      status_type                 status;
      logic [CLUSTER_W-1:0]       cluster;
   } result_type;

endpackage

### hw/rtl/fat_dir_entry_name_match.sv
// Top level of the FAT directory entry name match block.
//
// The block compares one 32-byte FAT32 directory entry per request against a
// configured 11-byte short name and answers each request with one status and,
// on a match, the entry's 32-bit first cluster. A new request is taken in every
// cycle unless the skid is full; results are registered. The only loop is the
// one-bit "search done" flag, which is updated in the same cycle the request is
// judged, so back-to-back requests of one search see each other's outcome.
// Results sit in an output register backed by a one-entry skid register, so
// the request side keeps flowing for one more request while the response side
// stalls; req_tready drops only when both hold a result. Deleted entries
// (first byte 0xE5) are skipped, a first byte of 0x00 ends the search, and a
// first byte of 0x05 is compared as 0xE5. search_start on a request reopens the
// search before that entry is judged. Configuration is written through the
// csr_ port, which is always ready, and should only be written while no result
// is outstanding.
module fat_dir_entry_name_match
   import fdm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata from bit 0: entry_name_low[63:0], entry_name_high[87:64],
   // entry_attr[95:88], cluster_high_half[111:96], cluster_low_half[127:112].
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // tuser: search_start.
   input  logic                   req_tuser,
   // tlast: listing_last.
   input  logic                   req_tlast,
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: start_cluster[31:0].
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: status[2:0].
   output logic [2:0]             rsp_tuser,
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers.
   logic [NAME_LOW_W-1:0]  target_low_ff,  target_low_in;
   logic [NAME_HIGH_W-1:0] target_high_ff, target_high_in;
   logic                   want_dir_ff,    want_dir_in;

   // Search state and output buffering.
   logic       search_done_ff, search_done_in;
   logic       out_valid_ff,   out_valid_in;
   logic       skid_valid_ff,  skid_valid_in;
   result_type out_ff,  out_in;
   result_type skid_ff, skid_in;

   // Request fields.
   logic [NAME_LOW_W-1:0]  entry_name_low;
   logic [NAME_HIGH_W-1:0] entry_name_high;
   logic [ATTR_W-1:0]      entry_attr;
   logic [HALF_W-1:0]      cluster_high_half;
   logic [HALF_W-1:0]      cluster_low_half;

   logic [NAME_LOW_W-1:0]  cmp_name_low;
   logic [7:0]             first_byte;
   logic                   done_eff;
   logic                   kind_ok;
   logic                   name_hit;
   logic                   req_accept;
   logic                   rsp_accept;
   result_type             result;

   assign entry_name_low    = req_tdata[NAME_LOW_W-1:0];
   assign entry_name_high   = req_tdata[NAME_LOW_W +: NAME_HIGH_W];
   assign entry_attr        = req_tdata[NAME_LOW_W + NAME_HIGH_W +: ATTR_W];
   assign cluster_high_half = req_tdata[NAME_LOW_W + NAME_HIGH_W + ATTR_W +: HALF_W];
   assign cluster_low_half  = req_tdata[NAME_LOW_W + NAME_HIGH_W + ATTR_W + HALF_W +: HALF_W];

   assign req_tready = ~skid_valid_ff;
   assign req_accept = req_tvalid & req_tready;
   assign rsp_accept = out_valid_ff & rsp_tready;
   assign csr_ready  = 1'b1;

   // A new search reopens the flag before this entry is judged.
   assign done_eff   = search_done_ff & ~req_tuser;
   assign first_byte = entry_name_low[7:0];

   // A leading 0x05 stands for a real 0xE5 in the name.
   assign cmp_name_low = (first_byte == KANJI_MARK)
                         ? {entry_name_low[NAME_LOW_W-1:8], DELETED_MARK}
                         : entry_name_low;

   assign kind_ok  = (entry_attr[DIR_ATTR_BIT] == want_dir_ff);
   assign name_hit = (cmp_name_low == target_low_ff) && (entry_name_high == target_high_ff);

   always_comb begin
      result.status  = ST_NONE;
      result.cluster = '0;
      if (done_eff) begin
         result.status = ST_IGNORED;
      end else if (first_byte == DELETED_MARK) begin
         if (req_tlast) begin
            result.status = ST_EXHAUSTED;
         end
      end else if (first_byte == END_MARK) begin
         result.status = ST_END;
      end else if (kind_ok && name_hit) begin
         result.status  = ST_FOUND;
         result.cluster = {cluster_high_half, cluster_low_half};
      end else if (req_tlast) begin
         result.status = ST_EXHAUSTED;
      end
   end

   // Every status other than "no match yet" leaves the search closed; an
   // ignored entry keeps it closed.
   always_comb begin
      search_done_in = search_done_ff;
      if (req_accept) begin
         search_done_in = (result.status != ST_NONE);
      end
   end

   // Output register with a one-entry skid behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (rsp_accept) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (req_accept) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (out_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      target_low_in  = target_low_ff;
      target_high_in = target_high_ff;
      want_dir_in    = want_dir_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TARGET_LOW:  target_low_in  = csr_data[NAME_LOW_W-1:0];
            REG_TARGET_HIGH: target_high_in = csr_data[NAME_HIGH_W-1:0];
            REG_WANT_DIR:    want_dir_in    = csr_data[0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_low_ff  <= TARGET_LOW_RESET;
         target_high_ff <= TARGET_HIGH_RESET;
         want_dir_ff    <= 1'b1;
         search_done_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         target_low_ff  <= target_low_in;
         target_high_ff <= target_high_in;
         want_dir_ff    <= want_dir_in;
         search_done_ff <= search_done_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.cluster;
   assign rsp_tuser  = out_ff.status;

endmodule

### hw/rtl/fdm_checker.sv
// Port-level checker for the FAT directory entry name match block, with its bind.
module fdm_checker
   import fdm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]            rsp_tuser
);

   // Reset empties the output buffering.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // With no result waiting, the skid is empty, so requests must be taken.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // Only a found entry carries a cluster.
   a_cluster_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_FOUND) |-> (rsp_tdata == '0))
      else $error("cluster reported without a match");

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= ST_IGNORED))
      else $error("undefined status code");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind fat_dir_entry_name_match fdm_checker u_fdm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### test/fdm_match_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the directory entry match responses.
package fdm_match_scoreboard_pkg;
   import fdm_pkg::*;

   class entry_lookup_scoreboard;
      logic [NAME_LOW_W-1:0]  target_low;
      logic [NAME_HIGH_W-1:0] target_high;
      bit                     want_dir;
      bit                     search_closed;
      result_type             due_results[$];
      int                     failures;
      int                     judged;
      int                     tally[5];

      function new();
         target_low    = TARGET_LOW_RESET;
         target_high   = TARGET_HIGH_RESET;
         want_dir      = 1'b1;
         search_closed = 1'b0;
         failures      = 0;
         judged        = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_TARGET_LOW:  target_low  = value[NAME_LOW_W-1:0];
            REG_TARGET_HIGH: target_high = value[NAME_HIGH_W-1:0];
            REG_WANT_DIR:    want_dir    = value[0];
            default: ;
         endcase
      endfunction

      // Judges one accepted directory entry and queues the response it must produce.
      function void note_entry(logic [REQ_DATA_W-1:0] data, bit start, bit last);
         logic [NAME_LOW_W-1:0]  name_low;
         logic [NAME_HIGH_W-1:0] name_high;
         logic [ATTR_W-1:0]      attr;
         logic [HALF_W-1:0]      clus_hi;
         logic [HALF_W-1:0]      clus_lo;
         result_type             verdict;
         name_low  = data[NAME_LOW_W-1:0];
         name_high = data[NAME_LOW_W +: NAME_HIGH_W];
         attr      = data[NAME_LOW_W + NAME_HIGH_W +: ATTR_W];
         clus_hi   = data[NAME_LOW_W + NAME_HIGH_W + ATTR_W +: HALF_W];
         clus_lo   = data[NAME_LOW_W + NAME_HIGH_W + ATTR_W + HALF_W +: HALF_W];
         verdict.status  = ST_NONE;
         verdict.cluster = '0;
         if (start) search_closed = 1'b0;
         if (search_closed) begin
            verdict.status = ST_IGNORED;
         end else if (name_low[7:0] == DELETED_MARK) begin
            if (last) begin
               verdict.status = ST_EXHAUSTED;
               search_closed  = 1'b1;
            end
         end else if (name_low[7:0] == END_MARK) begin
            verdict.status = ST_END;
            search_closed  = 1'b1;
         end else begin
            if (name_low[7:0] == KANJI_MARK) name_low[7:0] = DELETED_MARK;
            if (attr[DIR_ATTR_BIT] == want_dir && name_low == target_low
                && name_high == target_high) begin
               verdict.status  = ST_FOUND;
               verdict.cluster = {clus_hi, clus_lo};
               search_closed   = 1'b1;
            end else if (last) begin
               verdict.status = ST_EXHAUSTED;
               search_closed  = 1'b1;
            end
         end
         judged++;
         due_results = {due_results, verdict};
      endfunction

      function void check_result(logic [2:0] status_bits, logic [CLUSTER_W-1:0] cluster,
                                 time stamp);
         result_type due;
         if (due_results.size() == 0) begin
            $display("%0t: response with nothing outstanding, status %0d cluster %h",
                     stamp, status_bits, cluster);
            failures++;
            return;
         end
         due = due_results.pop_front();
         tally[due.status]++;
         if (status_bits !== due.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     stamp, due.status, status_bits);
            failures++;
         end
         if (cluster !== due.cluster) begin
            $display("%0t: start cluster mismatch, expected %h, actual %h",
                     stamp, due.cluster, cluster);
            failures++;
         end
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction
   endclass

endpackage

### test/tb_fat_dir_entry_name_match.sv
// Testbench for the FAT directory entry name match block.
module tb_fat_dir_entry_name_match;
   timeunit 1ns;
   timeprecision 1ps;
   import fdm_pkg::*;
   import fdm_match_scoreboard_pkg::*;

   localparam int unsigned ENTRY_NAME_W = NAME_LOW_W + NAME_HIGH_W;
   localparam logic [NAME_LOW_W-1:0]  SPACES_LOW  = 64'h2020_2020_2020_2020;
   localparam logic [NAME_HIGH_W-1:0] SPACES_HIGH = 24'h20_2020;
   // "\xE5HELLO  TXT": a short name whose first byte is the deleted mark, so it can
   // only be found through an entry that stores 0x05 in its place.
   localparam logic [NAME_LOW_W-1:0]  ESC_LOW     = 64'h2020_4F4C_4C45_48E5;
   localparam logic [NAME_HIGH_W-1:0] ESC_HIGH    = 24'h54_5854;
   localparam logic [NAME_LOW_W-1:0]  ESC_LOW_05  = {ESC_LOW[63:8], KANJI_MARK};
   localparam int JUDGED_GOAL = 1350;
   localparam int PHASES      = 12;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata   = '0;
   logic                   req_tuser   = 1'b0;
   logic                   req_tlast   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   entry_lookup_scoreboard sb;

   // Stimulus-side copy of the current target, used only to shape the requests.
   logic [NAME_LOW_W-1:0]  tgt_low  = TARGET_LOW_RESET;
   logic [NAME_HIGH_W-1:0] tgt_high = TARGET_HIGH_RESET;
   bit                     tgt_dir  = 1'b1;

   // Percent chance of a stall after a request handshake, or of a new response stall.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int rsp_hold     = 0;
   int settings     = 0;

   fat_dir_entry_name_match u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // The response side drops tready in random bursts, counted down in rsp_hold.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
      end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_tready <= 1'b0;
         rsp_hold = $urandom_range(1, 9) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // All handshakes are observed here, at the edge where they complete. Signals are
   // read before any of this edge's nonblocking updates land, so the values seen are
   // exactly the ones the block sampled. A response can never complete at the same
   // edge as the request that caused it, so checking before noting is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata, $time);
         if (req_tvalid && req_tready) sb.note_entry(req_tdata, req_tuser, req_tlast);
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_data);
      end
   end

   // Hard stop in case the block hangs; far above the slowest legal run.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [REQ_DATA_W-1:0] pack_entry(
      input logic [NAME_LOW_W-1:0] name_low, input logic [NAME_HIGH_W-1:0] name_high,
      input logic [ATTR_W-1:0] attr, input logic [HALF_W-1:0] clus_hi,
      input logic [HALF_W-1:0] clus_lo);
      return {clus_lo, clus_hi, attr, name_high, name_low};
   endfunction

   // One printable 8.3 character: a letter, a digit or the space used as padding.
   function automatic logic [7:0] name_char();
      int pick;
      pick = $urandom_range(0, 37);
      if (pick < 26) return 8'(8'h41 + pick);
      if (pick < 36) return 8'(8'h30 + pick - 26);
      return 8'h20;
   endfunction

   // Presents one request and waits for it to be taken. The valid stays high when no
   // stall follows, so back-to-back requests never lower and raise it in one step.
   task automatic send_entry(input logic [REQ_DATA_W-1:0] data, input bit start,
                             input bit last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= start;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_config(input logic [NAME_LOW_W-1:0] low,
                               input logic [NAME_HIGH_W-1:0] high, input bit dir);
      write_reg(REG_TARGET_LOW, low);
      write_reg(REG_TARGET_HIGH, {{(CSR_DATA_W - NAME_HIGH_W){1'b0}}, high});
      write_reg(REG_WANT_DIR, {{(CSR_DATA_W - 1){1'b0}}, dir});
      csr_valid <= 1'b0;
      tgt_low  = low;
      tgt_high = high;
      tgt_dir  = dir;
      settings++;
   endtask

   // Stops the request stream, waits until every response has come back, then idles.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic pick_target(input int phase);
      logic [NAME_LOW_W-1:0]  low;
      logic [NAME_HIGH_W-1:0] high;
      int style;
      style = (phase == 1) ? 3 : (phase == 2) ? 4 : $urandom_range(0, 2);
      for (int b = 0; b < 8; b++) low[8*b +: 8] = name_char();
      for (int b = 0; b < 3; b++) high[8*b +: 8] = name_char();
      case (style)
         0: begin
            low  = {$urandom, $urandom};
            high = NAME_HIGH_W'($urandom);
         end
         2: low[7:0] = DELETED_MARK;
         3: begin
            low  = '1;
            high = '1;
         end
         4: begin
            low  = '0;
            high = '0;
         end
         default: ;
      endcase
      write_config(low, high, phase[0]);
   endtask

   // One directory search: search_start on the first entry and tlast on the final
   // one, with a mix of matching, near-miss, deleted, wrong-kind and end entries.
   // About one search in five gets random start and last flags instead.
   task automatic run_search();
      int len;
      int hit_at;
      int kind;
      bit broken;
      bit start;
      bit last;
      logic [NAME_LOW_W + NAME_HIGH_W - 1:0] name;
      logic [ATTR_W-1:0] attr;
      len    = $urandom_range(1, 10);
      hit_at = ($urandom_range(0, 9) < 6) ? $urandom_range(0, len - 1) : -1;
      broken = ($urandom_range(0, 9) < 2);
      for (int k = 0; k < len; k++) begin
         kind = (k == hit_at) ? 100 : $urandom_range(0, 99);
         name = {tgt_high, tgt_low};
         attr = ATTR_W'($urandom);
         attr[DIR_ATTR_BIT] = tgt_dir;
         if (name[7:0] == DELETED_MARK && $urandom_range(0, 1)) name[7:0] = KANJI_MARK;
         if (kind < 30) begin
            name = ENTRY_NAME_W'({$urandom, $urandom, $urandom});
         end else if (kind < 50) begin
            name[$urandom_range(0, NAME_LOW_W + NAME_HIGH_W - 1)] ^= 1'b1;
         end else if (kind < 65) begin
            if ($urandom_range(0, 1)) name = ENTRY_NAME_W'({$urandom, $urandom, $urandom});
            name[7:0] = DELETED_MARK;
         end else if (kind < 70) begin
            name[7:0] = END_MARK;
         end else if (kind < 85) begin
            attr[DIR_ATTR_BIT] = ~tgt_dir;
         end
         start = (k == 0);
         last  = (k == len - 1);
         if (broken) begin
            start = 1'($urandom_range(0, 1));
            last  = ($urandom_range(0, 3) == 0);
         end
         send_entry(pack_entry(name[NAME_LOW_W-1:0], name[NAME_LOW_W +: NAME_HIGH_W], attr,
                               HALF_W'($urandom), HALF_W'($urandom)), start, last);
      end
   endtask

   initial begin
      int idle_choice[4];
      int goal;
      idle_choice = '{0, 10, 30, 60};
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first with the reset target of eleven spaces in directory mode.
      send_entry(pack_entry(SPACES_LOW, SPACES_HIGH, 8'h10, 16'hFFFF, 16'hFFFF), 1'b1, 1'b0);
      // Anything after a find is ignored until a new search starts.
      send_entry(pack_entry(SPACES_LOW, SPACES_HIGH, 8'h10, 16'h1234, 16'h5678), 1'b0, 1'b0);
      // A plain file never matches in directory mode.
      send_entry(pack_entry(SPACES_LOW, SPACES_HIGH, 8'h00, 16'h0000, 16'h0000), 1'b1, 1'b0);
      // Deleted entries are skipped, and end the search only when they are last.
      send_entry(pack_entry({SPACES_LOW[63:8], DELETED_MARK}, SPACES_HIGH, 8'h10,
                            16'h0, 16'h0), 1'b0, 1'b0);
      send_entry(pack_entry({SPACES_LOW[63:8], DELETED_MARK}, SPACES_HIGH, 8'h10,
                            16'h0, 16'h0), 1'b0, 1'b1);
      send_entry(pack_entry({SPACES_LOW[63:8], END_MARK}, SPACES_HIGH, 8'h10,
                            16'h0, 16'h0), 1'b0, 1'b0);
      // End marker together with start and last.
      send_entry(pack_entry({SPACES_LOW[63:8], END_MARK}, SPACES_HIGH, 8'h10,
                            16'h0, 16'h0), 1'b1, 1'b1);
      send_entry(pack_entry('1, '1, '1, '1, '1), 1'b1, 1'b1);
      settle();

      // File mode with a target whose first byte is the deleted mark.
      write_config(ESC_LOW, ESC_HIGH, 1'b0);
      send_entry(pack_entry(ESC_LOW_05, ESC_HIGH, 8'h20, 16'h0001, 16'h0002), 1'b1, 1'b0);
      // The same name stored with 0xE5 is a deleted entry, not a match.
      send_entry(pack_entry(ESC_LOW, ESC_HIGH, 8'h00, 16'h0003, 16'h0004), 1'b1, 1'b0);
      send_entry(pack_entry(ESC_LOW_05, ESC_HIGH, 8'hEF, 16'h0000, 16'h0000), 1'b0, 1'b0);
      send_entry(pack_entry(ESC_LOW_05, ESC_HIGH, 8'h10, 16'h1111, 16'h2222), 1'b1, 1'b0);
      send_entry(pack_entry(ESC_LOW_05, ESC_HIGH, 8'hFF, 16'h3333, 16'h4444), 1'b0, 1'b1);
      // Single-bit misses at the edges of the eleven compared bytes.
      send_entry(pack_entry(ESC_LOW_05, ESC_HIGH ^ 24'h80_0000, 8'h00, 16'h0, 16'h0),
                 1'b1, 1'b0);
      send_entry(pack_entry(ESC_LOW_05, ESC_HIGH ^ 24'h00_0001, 8'h00, 16'h0, 16'h0),
                 1'b0, 1'b0);
      send_entry(pack_entry(ESC_LOW_05 ^ {1'b1, 63'b0}, ESC_HIGH, 8'h00, 16'h0, 16'h0),
                 1'b0, 1'b0);
      send_entry(pack_entry(ESC_LOW_05, ESC_HIGH, 8'h00, 16'hFFFF, 16'h0000), 1'b1, 1'b1);
      settle();

      // All-ones target in directory mode.
      write_config('1, '1, 1'b1);
      send_entry(pack_entry({56'hFF_FFFF_FFFF_FFFF, END_MARK}, '1, '1, '1, '1), 1'b1, 1'b0);
      send_entry(pack_entry('1, '1, '1, '1, '1), 1'b0, 1'b0);
      send_entry(pack_entry('1, '1, '1, '1, '1), 1'b1, 1'b1);
      settle();

      // All-zero target: the matching entry reads as an end marker.
      write_config('0, '0, 1'b1);
      send_entry(pack_entry('0, '0, 8'h10, 16'h0, 16'h0), 1'b1, 1'b0);
      send_entry(pack_entry(64'h1, '0, 8'h10, 16'h0, 16'h0), 1'b1, 1'b0);
      send_entry(pack_entry({56'h0, DELETED_MARK}, '0, 8'h10, 16'h0, 16'h0), 1'b0, 1'b1);
      settle();

      // Random part in phases, each with its own target, mode and stall rates. The
      // last phase runs with both sides always ready.
      for (int phase = 0; phase < PHASES; phase++) begin
         pick_target(phase);
         if (phase == PHASES - 1) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = idle_choice[$urandom_range(0, 3)];
            rsp_idle_pct = idle_choice[$urandom_range(0, 3)];
         end
         goal = (phase + 1) * JUDGED_GOAL / PHASES;
         while (sb.judged < goal) run_search();
         settle();
      end

      repeat (8) @(posedge clock);
      $display("Checked %0d responses: %0d found, %0d end marker, %0d exhausted,",
               sb.tally[ST_FOUND] + sb.tally[ST_END] + sb.tally[ST_EXHAUSTED]
               + sb.tally[ST_NONE] + sb.tally[ST_IGNORED], sb.tally[ST_FOUND],
               sb.tally[ST_END], sb.tally[ST_EXHAUSTED]);
      $display("%0d open and %0d ignored, under %0d target settings in both modes.",
               sb.tally[ST_NONE], sb.tally[ST_IGNORED], settings);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
